// ===== sv/pidrob_pkg.sv =====
// ----------------------------------------------------------------------------
// Per-id reorder buffer package
// Transaction field types, sequencer states and fixed constants shared by
// the reorder buffer modules.
// ----------------------------------------------------------------------------
package pidrob_pkg;

    // Fixed field widths of the request and release transactions.
    localparam int SRC_W       = 4;
    localparam int TID_W       = 5;
    localparam int SEQ_FIELD_W = 4;
    localparam int PAY_FIELD_W = 32;

    // Upper bound on the number of requests released by one input.
    localparam int MAX_RUN = 16;
    localparam int CNT_W   = $clog2(MAX_RUN + 1);

    // Incoming request transaction.
    typedef struct packed {
        logic [SRC_W-1:0]       source_index;
        logic [TID_W-1:0]       trans_id;
        logic [SEQ_FIELD_W-1:0] seq_num;
        logic [PAY_FIELD_W-1:0] payload;
    } t_req;

    // Released request transaction.
    typedef struct packed {
        logic [SRC_W-1:0]       out_source;
        logic [TID_W-1:0]       out_trans_id;
        logic [SEQ_FIELD_W-1:0] out_seq;
        logic [PAY_FIELD_W-1:0] out_payload;
        logic                   last_of_run;
    } t_rsp;

    // Sequencer states.
    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_DRAIN
    } t_state;

endpackage

// ===== sv/pidrob_ram.sv =====
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module pidrob_ram #(
    parameter int  WIDTH = 8,
    parameter int  DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port; the data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/pidrob_ostage.sv =====
// ----------------------------------------------------------------------------
// Reorder buffer output stage
// Holds one released transaction until the downstream side takes it.
// ----------------------------------------------------------------------------
module pidrob_ostage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  pidrob_pkg::t_rsp  i_data,
    input  logic              i_ready,
    output logic              o_valid,
    output pidrob_pkg::t_rsp  o_data,
    output logic              o_free
);
    import pidrob_pkg::*;

    logic r_valid;
    t_rsp r_data;

    // The stage can be refilled when empty or when its content leaves now.
    assign o_free = !r_valid || i_ready;

    // Valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    // Payload register.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= i_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ===== sv/per_id_sequence_reorder_buffer_unit.sv =====
// ----------------------------------------------------------------------------
// Per-id sequence reorder buffer
// Stores requests by (source, id, sequence) and releases them in sequence
// order per (source, id) pair, flagging the last request of each run.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                    Payload
//  request   in         i_in_valid  / o_in_ready     i_in_data  (t_req)
//  release   out        o_out_valid / i_out_ready    o_out_data (t_rsp)
//
// An item is accepted in S_IDLE; S_DRAIN then issues the payload reads of its
// run one after another through the single payload read port.
// The per-pair row (valid bits and expected pointer) is read on acceptance and
// written back when the run ends. Items with an address out of range are accepted but not stored.
// After reset a clearing pass zeroes all NUM_SOURCES*NUM_IDS rows.
// A stalled release side holds the run at the next payload read.
//
module per_id_sequence_reorder_buffer_unit #(
    parameter int NUM_SOURCES   = 16,
    parameter int NUM_IDS       = 32,
    parameter int SEQ_DEPTH     = 16,
    parameter int PAYLOAD_WIDTH = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  pidrob_pkg::t_req i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output pidrob_pkg::t_rsp o_out_data
);
    import pidrob_pkg::*;

    localparam int NUM_PAIRS = NUM_SOURCES * NUM_IDS;
    localparam int NUM_SLOTS = NUM_PAIRS * SEQ_DEPTH;
    localparam int PAIR_W    = (NUM_PAIRS > 1) ? $clog2(NUM_PAIRS) : 1;
    localparam int SLOT_W    = $clog2(NUM_SLOTS);
    localparam int SEQ_W     = $clog2(SEQ_DEPTH);
    localparam int ROW_W     = SEQ_DEPTH + SEQ_W;
    localparam logic [SEQ_DEPTH-1:0] ONE_HOT0 = SEQ_DEPTH'(1);

    t_state r_state, n_state;
    logic [PAIR_W-1:0]    r_clr, n_clr;
    logic                 r_first, n_first;
    logic [SEQ_DEPTH-1:0] r_vec, n_vec;
    logic [SEQ_W-1:0]     r_ptr, n_ptr;
    logic [CNT_W-1:0]     r_cnt, n_cnt;

    // Fields of the item being drained.
    logic [SRC_W-1:0]  r_src;
    logic [TID_W-1:0]  r_tid;
    logic [SEQ_W-1:0]  r_seq;
    logic [PAIR_W-1:0] r_pair;
    logic [SLOT_W-1:0] r_base;

    // Tag of the payload read in flight.
    logic                   r_pend;
    logic [SRC_W-1:0]       r_pend_src;
    logic [TID_W-1:0]       r_pend_tid;
    logic [SEQ_FIELD_W-1:0] r_pend_seq;
    logic                   r_pend_last;

    logic                     w_accept, w_in_range, w_store;
    logic [PAIR_W-1:0]        w_pair;
    logic [SLOT_W-1:0]        w_base, w_slot;
    logic                     w_st_we;
    logic [PAIR_W-1:0]        w_st_waddr;
    logic [ROW_W-1:0]         w_st_wdata, w_st_rdata;
    logic                     w_issue;
    logic [PAYLOAD_WIDTH-1:0] w_pay_wdata, w_pay_rdata;
    logic [SEQ_DEPTH-1:0]     w_cur_vec, w_vec_n;
    logic [SEQ_W-1:0]         w_cur_ptr, w_ptr_n;
    logic [CNT_W-1:0]         w_cnt_n;
    logic                     w_hit, w_last, w_slot_free;
    logic                     w_load, w_free;
    t_rsp                     w_rsp;

    // Input decode: range check and memory addresses.
    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_in_range = (32'(i_in_data.source_index) < 32'(NUM_SOURCES)) &&
                        (32'(i_in_data.trans_id) < 32'(NUM_IDS)) &&
                        (32'(i_in_data.seq_num) < 32'(SEQ_DEPTH));
    assign w_store    = w_accept && w_in_range;
    assign w_pair     = PAIR_W'(32'(i_in_data.source_index) * NUM_IDS +
                                32'(i_in_data.trans_id));
    assign w_base     = SLOT_W'(32'(i_in_data.source_index) * (NUM_IDS * SEQ_DEPTH) +
                                32'(i_in_data.trans_id) * SEQ_DEPTH);
    assign w_slot     = w_base + SLOT_W'(i_in_data.seq_num);
    assign w_pay_wdata = PAYLOAD_WIDTH'(i_in_data.payload);

    // Per-pair row memory: valid bits above, expected pointer below.
    pidrob_ram #(
        .WIDTH (ROW_W),
        .DEPTH (NUM_PAIRS)
    ) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (w_st_we),
        .i_waddr (w_st_waddr),
        .i_wdata (w_st_wdata),
        .i_re    (w_store),
        .i_raddr (w_pair),
        .o_rdata (w_st_rdata)
    );

    // Payload memory, one entry per slot.
    pidrob_ram #(
        .WIDTH (PAYLOAD_WIDTH),
        .DEPTH (NUM_SLOTS)
    ) u_pay_ram (
        .i_clk   (i_clk),
        .i_we    (w_store),
        .i_waddr (w_slot),
        .i_wdata (w_pay_wdata),
        .i_re    (w_issue),
        .i_raddr (r_base + SLOT_W'(w_cur_ptr)),
        .o_rdata (w_pay_rdata)
    );

    // Working copy of the row: fresh from memory on the first drain cycle.
    assign w_cur_vec   = r_first ? (w_st_rdata[ROW_W-1:SEQ_W] | (ONE_HOT0 << r_seq))
                                 : r_vec;
    assign w_cur_ptr   = r_first ? w_st_rdata[SEQ_W-1:0] : r_ptr;
    assign w_hit       = w_cur_vec[w_cur_ptr];
    assign w_vec_n     = w_cur_vec & ~(ONE_HOT0 << w_cur_ptr);
    assign w_ptr_n     = (w_cur_ptr == SEQ_W'(SEQ_DEPTH - 1)) ? '0 : w_cur_ptr + 1'b1;
    assign w_cnt_n     = r_cnt + 1'b1;
    assign w_last      = !w_vec_n[w_ptr_n] || (w_cnt_n == CNT_W'(MAX_RUN));
    assign w_load      = r_pend && w_free;
    assign w_slot_free = !r_pend || w_load;

    // Sequencer state register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_first <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_first <= n_first;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_vec <= n_vec;
        r_ptr <= n_ptr;
    end

    // Next state, row write-back and payload read issue.
    always_comb begin
        n_state    = r_state;
        n_clr      = r_clr;
        n_first    = r_first;
        n_cnt      = r_cnt;
        n_vec      = r_vec;
        n_ptr      = r_ptr;
        w_st_we    = 1'b0;
        w_st_waddr = r_pair;
        w_st_wdata = {w_cur_vec, w_cur_ptr};
        w_issue    = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                w_st_we    = 1'b1;
                w_st_waddr = r_clr;
                w_st_wdata = '0;
                n_clr      = r_clr + 1'b1;
                if (r_clr == PAIR_W'(NUM_PAIRS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_store) begin
                    n_state = S_DRAIN;
                    n_first = 1'b1;
                    n_cnt   = '0;
                end
            end
            S_DRAIN: begin
                if (!w_hit) begin
                    // Nothing in order yet: store the new valid bit only.
                    w_st_we = 1'b1;
                    n_first = 1'b0;
                    n_state = S_IDLE;
                end else if (w_slot_free) begin
                    w_issue = 1'b1;
                    n_cnt   = w_cnt_n;
                    n_first = 1'b0;
                    n_vec   = w_vec_n;
                    n_ptr   = w_ptr_n;
                    if (w_last) begin
                        w_st_we    = 1'b1;
                        w_st_wdata = {w_vec_n, w_ptr_n};
                        n_state    = S_IDLE;
                    end
                end else begin
                    // Output side stalled: keep the row in registers.
                    n_first = 1'b0;
                    n_vec   = w_cur_vec;
                    n_ptr   = w_cur_ptr;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Capture the fields of an accepted item.
    always_ff @(posedge i_clk) begin
        if (w_store) begin
            r_src  <= i_in_data.source_index;
            r_tid  <= i_in_data.trans_id;
            r_seq  <= SEQ_W'(i_in_data.seq_num);
            r_pair <= w_pair;
            r_base <= w_base;
        end
    end

    // Payload read in flight and its tag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
        end else if (w_issue) begin
            r_pend <= 1'b1;
        end else if (w_load) begin
            r_pend <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_issue) begin
            r_pend_src  <= r_src;
            r_pend_tid  <= r_tid;
            r_pend_seq  <= SEQ_FIELD_W'(w_cur_ptr);
            r_pend_last <= w_last;
        end
    end

    // Assemble the release transaction from the tag and the read data.
    always_comb begin
        w_rsp.out_source   = r_pend_src;
        w_rsp.out_trans_id = r_pend_tid;
        w_rsp.out_seq      = r_pend_seq;
        w_rsp.out_payload  = PAY_FIELD_W'(w_pay_rdata);
        w_rsp.last_of_run  = r_pend_last;
    end

    pidrob_ostage u_ostage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_load),
        .i_data  (w_rsp),
        .i_ready (i_out_ready),
        .o_valid (o_out_valid),
        .o_data  (o_out_data),
        .o_free  (w_free)
    );

`ifndef SYNTHESIS
    // A run always ends with the pair row written back.
    a_wb_on_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRAIN && n_state == S_IDLE) |-> w_st_we)
        else $error("drain ended without row write-back");

    // Read data waiting for the output stage is never lost.
    a_pend_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend && !w_load && !w_issue) |=> r_pend)
        else $error("pending payload dropped");

    // No payload read may overwrite read data that has not been taken.
    a_issue_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_issue |-> (!r_pend || w_load))
        else $error("payload read overwrote pending data");

    // Nothing is released or accepted during the clearing pass.
    a_clear_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> (!w_issue && !o_in_ready && !r_pend))
        else $error("activity during clearing pass");
`endif

endmodule
